>>> rtl/wst_pkg.sv
`timescale 1ns / 1ps
// Package for the station tracker: request and result payload types, queue entry type,
// frame classification codes, outcome codes and fixed constants. No dependencies.
package wst_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [11:0] MIN_FRAME_BYTES = 12'd24;
  localparam logic [1:0]  KIND_DATA       = 2'd2;

  localparam logic [1:0] SCAN_STATIONS = 2'd1;
  localparam logic [1:0] SCAN_BOTH     = 2'd2;
  localparam logic [1:0] SCAN_RESET    = SCAN_BOTH;

  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_WDS     = 3'd1;
  localparam logic [2:0] OUT_UPDATED = 3'd2;
  localparam logic [2:0] OUT_ADDED   = 3'd3;
  localparam logic [2:0] OUT_FULL    = 3'd4;

  typedef enum logic [1:0] {
    CLS_IGNORE = 2'd0,
    CLS_WDS    = 2'd1,
    CLS_LOOKUP = 2'd2
  } cls_e;

  typedef struct packed {
    logic [11:0]        frame_length;
    logic [1:0]         frame_kind;
    logic               to_ds;
    logic               from_ds;
    logic [47:0]        address_one;
    logic [47:0]        address_two;
    logic signed [7:0]  signal_strength;
    logic [3:0]         radio_channel;
    logic [31:0]        timestamp;
  } wst_in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [47:0] station_address;
    logic [47:0] access_point_address;
    logic [4:0]  entry_index;
    logic [31:0] packet_total;
  } wst_out_t;

  typedef struct packed {
    cls_e               cls;
    logic [47:0]        sta;
    logic [47:0]        ap;
    logic signed [7:0]  rssi;
    logic [3:0]         chan;
    logic [31:0]        stamp;
  } entry_t;

endpackage

>>> rtl/wst_front.sv
`timescale 1ns / 1ps
// Front end: scan target register, request acceptance, classification and address pick.
// Depends on wst_pkg.
module wst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wst_pkg::wst_in_t in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output wst_pkg::entry_t  q_entry_o
);

  logic [1:0] scan_q;
  logic       ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= wst_pkg::SCAN_RESET;
    end else if (cfg_we_i) begin
      scan_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign ignore = (in_data_i.frame_length < wst_pkg::MIN_FRAME_BYTES) ||
                  (in_data_i.frame_kind != wst_pkg::KIND_DATA) ||
                  ((scan_q != wst_pkg::SCAN_STATIONS) && (scan_q != wst_pkg::SCAN_BOTH));

  always_comb begin
    q_entry_o       = '0;
    q_entry_o.rssi  = in_data_i.signal_strength;
    q_entry_o.chan  = in_data_i.radio_channel;
    q_entry_o.stamp = in_data_i.timestamp;
    if (ignore) begin
      q_entry_o.cls = wst_pkg::CLS_IGNORE;
    end else if (in_data_i.to_ds && in_data_i.from_ds) begin
      q_entry_o.cls = wst_pkg::CLS_WDS;
    end else if (in_data_i.from_ds) begin
      q_entry_o.cls = wst_pkg::CLS_LOOKUP;
      q_entry_o.sta = in_data_i.address_one;
      q_entry_o.ap  = in_data_i.address_two;
    end else begin
      q_entry_o.cls = wst_pkg::CLS_LOOKUP;
      q_entry_o.sta = in_data_i.address_two;
      q_entry_o.ap  = in_data_i.address_one;
    end
  end

endmodule

>>> rtl/wst_queue.sv
`timescale 1ns / 1ps
// Short request queue between front end and table engine.
// Depends on wst_pkg.
module wst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wst_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output wst_pkg::entry_t head_o
);

  localparam int unsigned PTR_W = (wst_pkg::QUEUE_DEPTH > 1) ? $clog2(wst_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(wst_pkg::QUEUE_DEPTH + 1);

  wst_pkg::entry_t  slot_q [wst_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(wst_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(wst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(wst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> rtl/wst_back.sv
`timescale 1ns / 1ps
// Table engine: station key match, entry memories, update/append and result register.
// Depends on wst_pkg.
module wst_back #(
  parameter int unsigned TABLE_DEPTH = wst_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  wst_pkg::entry_t   q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wst_pkg::wst_out_t out_data_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  wst_pkg::entry_t   cur_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  wst_pkg::wst_out_t out_data_q, out_d;
  logic              out_load, out_free, cur_load, tbl_we;

  logic [47:0]       key_q [TABLE_DEPTH];
  logic [47:0]       ap_mem [TABLE_DEPTH];
  logic [7:0]        rssi_mem [TABLE_DEPTH];
  logic [3:0]        chan_mem [TABLE_DEPTH];
  logic [31:0]       seen_mem [TABLE_DEPTH];
  logic [31:0]       pkt_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] lane_hit, match_q;
  logic              enc_hit, hit_q;
  logic [IDX_W-1:0]  enc_idx, hit_idx_q, wr_idx;
  logic [31:0]       pkt_rd_q, pkt_next;
  logic              tbl_full;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_lane
    assign lane_hit[g] = (key_q[g] == cur_q.sta) && (CNT_W'(g) < count_q);
  end

  always_comb begin
    enc_hit = 1'b0;
    enc_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        enc_hit = 1'b1;
        enc_idx = IDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign tbl_full = (count_q == CNT_W'(TABLE_DEPTH));
  assign pkt_next = (pkt_rd_q == 32'hFFFF_FFFF) ? pkt_rd_q : pkt_rd_q + 32'd1;
  assign wr_idx   = hit_q ? hit_idx_q : count_q[IDX_W-1:0];

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    q_pop_o  = 1'b0;
    cur_load = 1'b0;
    out_load = 1'b0;
    tbl_we   = 1'b0;
    out_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.cls)
            wst_pkg::CLS_LOOKUP: begin
              q_pop_o  = 1'b1;
              cur_load = 1'b1;
              state_d  = S_MATCH;
            end
            wst_pkg::CLS_WDS: begin
              if (out_free) begin
                q_pop_o       = 1'b1;
                out_load      = 1'b1;
                out_d.outcome = wst_pkg::OUT_WDS;
              end
            end
            default: begin
              if (out_free) begin
                q_pop_o       = 1'b1;
                out_load      = 1'b1;
                out_d.outcome = wst_pkg::OUT_IGNORED;
              end
            end
          endcase
        end
      end
      S_MATCH: state_d = S_READ;
      S_READ:  state_d = S_WRITE;
      S_WRITE: begin
        if (out_free) begin
          out_load                   = 1'b1;
          state_d                    = S_IDLE;
          out_d.station_address      = cur_q.sta;
          out_d.access_point_address = cur_q.ap;
          if (hit_q) begin
            tbl_we             = 1'b1;
            out_d.outcome      = wst_pkg::OUT_UPDATED;
            out_d.entry_index  = 5'(hit_idx_q);
            out_d.packet_total = pkt_next;
          end else if (!tbl_full) begin
            tbl_we             = 1'b1;
            count_d            = CNT_W'(count_q + 1'b1);
            out_d.outcome      = wst_pkg::OUT_ADDED;
            out_d.entry_index  = 5'(count_q);
            out_d.packet_total = 32'd1;
          end else begin
            out_d.outcome = wst_pkg::OUT_FULL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_q <= q_entry_i;
    end
    if (out_load) begin
      out_data_q <= out_d;
    end
    if (state_q == S_MATCH) begin
      match_q <= lane_hit;
    end
    if (state_q == S_READ) begin
      hit_q     <= enc_hit;
      hit_idx_q <= enc_idx;
      pkt_rd_q  <= pkt_mem[enc_idx];
    end
    if (tbl_we) begin
      rssi_mem[wr_idx] <= cur_q.rssi;
      seen_mem[wr_idx] <= cur_q.stamp;
      if (hit_q) begin
        pkt_mem[wr_idx] <= pkt_next;
      end else begin
        pkt_mem[wr_idx]  <= 32'd1;
        key_q[wr_idx]    <= cur_q.sta;
        ap_mem[wr_idx]   <= cur_q.ap;
        chan_mem[wr_idx] <= cur_q.chan;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("station count beyond table depth");

  a_count_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_WRITE) |=> (count_q == $past(count_q)))
    else $error("station count moved outside write step");

  a_hit_in_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && hit_q) |-> match_q[hit_idx_q])
    else $error("hit slot not in match vector");

  a_hit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && hit_q) |-> (CNT_W'(hit_idx_q) < count_q))
    else $error("hit slot beyond filled entries");

  a_add_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.outcome == wst_pkg::OUT_ADDED) |-> !tbl_full)
    else $error("append into full table");

endmodule

>>> rtl/wifi_station_tracker.sv
`timescale 1ns / 1ps
// Top level of the station tracker: front end, request queue and table engine.
// Depends on wst_pkg, wst_front, wst_queue, wst_back.
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_ready_o  in_data_i   (wst_in_t)
//   out       output     out_valid_o/ out_ready_i out_data_o  (wst_out_t)
//   cfg       input      cfg_we_i                 cfg_wdata_i (scan target)
//
// A lookup request goes through match, memory read and write back in the table
// engine; ignored and WDS requests skip them. The table engine handles one
// request at a time; the queue lets the front end take two more meanwhile.
// Reset empties the table at once (fill count cleared); no clearing pass.
// A stalled result holds the engine; the front end stalls only when the queue is full.
module wifi_station_tracker #(
  parameter int unsigned TABLE_DEPTH = wst_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wst_pkg::wst_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wst_pkg::wst_out_t out_data_o
);

  logic            q_push, q_full, q_pop, q_valid;
  wst_pkg::entry_t q_push_entry, q_head;

  wst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_push_entry)
  );

  wst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  wst_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
